FILE: hw/rtl/mpfde_pkg.sv
// ----------------------------------------------------------------------------
// Draw engine package
// Shared types, sizes and command codes for the page framebuffer draw engine.
// ----------------------------------------------------------------------------
package mpfde_pkg;

   localparam int Columns  = 128;
   localparam int Pages    = 8;
   localparam int Depth    = Columns * Pages;
   localparam int AddrBits = $clog2(Depth);
   localparam int PageBits = (Pages > 1) ? $clog2(Pages) : 1;
   localparam int ColBits  = $clog2(Columns);

   localparam logic [2:0] CMD_READ   = 3'd0;
   localparam logic [2:0] CMD_CLEAR  = 3'd1;
   localparam logic [2:0] CMD_PIXEL  = 3'd2;
   localparam logic [2:0] CMD_FILL   = 3'd3;
   localparam logic [2:0] CMD_RECT   = 3'd4;
   localparam logic [2:0] CMD_LINE   = 3'd5;
   localparam logic [2:0] CMD_CIRCLE = 3'd6;

   localparam logic CSR_X_LIMIT = 1'b0;
   localparam logic CSR_Y_LIMIT = 1'b1;

   typedef struct packed {
      logic [2:0] cmd;
      logic [6:0] x_a;
      logic [5:0] y_a;
      logic [6:0] x_b;
      logic [5:0] y_b;
      logic [6:0] radius;
      logic [7:0] width;
      logic [6:0] height;
      logic       mode;
      logic [2:0] page;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] done_cmd;
   } rsp_type;

endpackage

FILE: hw/rtl/monochrome_page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// Monochrome page framebuffer draw engine
// Line, circle, rectangle, fill and pixel rasteriser over a page framebuffer.
// ----------------------------------------------------------------------------
// Each command ends in a result strobe. A drawing command takes every kept pixel through
// generate, address, read and write back, and every dropped one through generate and
// address only (circle: 8 pixels per step). One command at a time; busy is high until
// the strobe cycle, so the next command can be taken as the strobe ends. Results come
// as a one-cycle strobe that the receiver cannot stall. After reset a pass over every
// word zeroes the store.
// ----------------------------------------------------------------------------
module monochrome_page_framebuffer_draw_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mpfde_pkg::req_type  req_item,
   output logic                rsp_valid,
   output mpfde_pkg::rsp_type  rsp_item,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [6:0]          csr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_GEN, ST_RD, ST_WAIT, ST_WR, ST_READ1, ST_READ2, ST_DONE
   } state_type;

   state_type state_ff;
   mpfde_pkg::req_type req_ff;
   logic [6:0] x_limit_ff;
   logic [5:0] y_limit_ff;
   logic [mpfde_pkg::AddrBits:0] clr_ff;
   // Walk registers: signed 12-bit coordinates and errors.
   logic signed [11:0] cx_ff, cy_ff, err_ff, xch_ff, ych_ff, sx_ff, sy_ff;
   logic signed [11:0] dx_ff, dy_ff;
   logic [8:0] j_ff;
   logic [1:0] phase_ff;
   logic [2:0] oct_ff;
   logic       first_ff;
   // Pending pixel.
   logic [7:0] px_ff, py_ff;
   logic       pon_ff;
   logic [mpfde_pkg::AddrBits-1:0] addr_ff;
   logic [7:0] mask_ff;
   logic       ret_done_ff;
   logic       rsp_valid_ff;
   logic [7:0] rd_byte_ff;

   logic       ram_we;
   logic [mpfde_pkg::AddrBits-1:0] ram_addr;
   logic [7:0] ram_wd, ram_rd;

   mpfde_ram #(.Width(8), .Depth(mpfde_pkg::Depth)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // Pixel acceptance and page for the pending pixel.
   logic       px_ok;
   logic [2:0] px_pg;
   always_comb begin
      px_pg = 3'd7 - py_ff[5:3];
      px_ok = ({1'b0, px_ff} <= {2'b0, x_limit_ff}) && (py_ff <= {2'b0, y_limit_ff})
              && ({1'b0, px_ff} < 9'(mpfde_pkg::Columns))
              && ({1'b0, px_pg} < 4'(mpfde_pkg::Pages));
   end

   // Store port selection.
   always_comb begin
      ram_we   = 1'b0;
      ram_wd   = pon_ff ? (ram_rd | mask_ff) : (ram_rd & ~mask_ff);
      ram_addr = addr_ff;
      if (state_ff == ST_CLEAR) begin
         ram_we   = 1'b1;
         ram_wd   = '0;
         ram_addr = clr_ff[mpfde_pkg::AddrBits-1:0];
      end else if (state_ff == ST_WR) begin
         ram_we = 1'b1;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item.read_data = rd_byte_ff;
   assign rsp_item.done_cmd  = req_ff.cmd;

   // Helpers for the next generated pixel.
   logic signed [11:0] ox, oy, e2;
   logic [7:0] gx, gy;
   logic       gvalid, gdone;
   logic signed [11:0] ncx, ncy, nerr, nxch, nych;
   logic [8:0] nj;
   logic [1:0] nphase;
   logic [2:0] noct;

   always_comb begin
      gx = '0; gy = '0; gvalid = 1'b0; gdone = 1'b0;
      ncx = cx_ff; ncy = cy_ff; nerr = err_ff; nxch = xch_ff; nych = ych_ff;
      nj = j_ff; nphase = phase_ff; noct = oct_ff;
      ox = '0; oy = '0; e2 = '0;
      case (req_ff.cmd)
         mpfde_pkg::CMD_PIXEL: begin
            gx = {1'b0, req_ff.x_a}; gy = {2'b0, req_ff.y_a};
            gvalid = first_ff; gdone = !first_ff;
         end
         mpfde_pkg::CMD_FILL: begin
            // cx column, cy row, column-major: inner loop over rows
            if (req_ff.x_a > req_ff.x_b || req_ff.y_a > req_ff.y_b
                || cx_ff > $signed({5'b0, req_ff.x_b})) begin
               gdone = 1'b1;
            end else begin
               gx = cx_ff[7:0]; gy = cy_ff[7:0]; gvalid = 1'b1;
               if (cy_ff == $signed({6'b0, req_ff.y_b})) begin
                  ncy = $signed({6'b0, req_ff.y_a}); ncx = cx_ff + 12'sd1;
               end else begin
                  ncy = cy_ff + 12'sd1;
               end
            end
         end
         mpfde_pkg::CMD_RECT: begin
            if (phase_ff == 2'd0) begin
               if (j_ff >= {2'b0, req_ff.height}) begin
                  gdone = 1'b1; nphase = 2'd2; nj = '0; noct = '0;
               end else begin
                  gvalid = 1'b1;
                  gy = 8'({2'b0, req_ff.y_a} + j_ff[7:0]);
                  gx = oct_ff[0] ? 8'({1'b0, req_ff.x_a} + req_ff.width - 8'd1)
                                 : {1'b0, req_ff.x_a};
                  noct = {2'b0, ~oct_ff[0]};
                  if (oct_ff[0]) nj = j_ff + 9'd1;
               end
               gdone = 1'b0;
               if (j_ff >= {2'b0, req_ff.height}) begin
                  gvalid = 1'b0;
               end
            end else begin
               if (j_ff >= {1'b0, req_ff.width}) begin
                  gdone = 1'b1;
               end else begin
                  gvalid = 1'b1;
                  gx = 8'({1'b0, req_ff.x_a} + j_ff[7:0]);
                  gy = oct_ff[0] ? 8'({2'b0, req_ff.y_a} + {1'b0, req_ff.height} - 8'd1)
                                 : {2'b0, req_ff.y_a};
                  noct = {2'b0, ~oct_ff[0]};
                  if (oct_ff[0]) nj = j_ff + 9'd1;
               end
            end
         end
         mpfde_pkg::CMD_LINE: begin
            gx = cx_ff[7:0]; gy = cy_ff[7:0];
            if (first_ff) begin
               gvalid = 1'b1;
            end else if ((dx_ff == 0 && dy_ff == 0) || phase_ff == 2'd1) begin
               gdone = 1'b1;
            end else if (dy_ff <= dx_ff) begin
               ncx = cx_ff + sx_ff;
               nerr = err_ff + (dy_ff <<< 1);
               ncy = cy_ff;
               if (nerr > dx_ff) begin ncy = cy_ff + sy_ff; nerr = nerr - (dx_ff <<< 1); end
               gx = ncx[7:0]; gy = ncy[7:0]; gvalid = 1'b1;
               if (ncx == $signed({5'b0, req_ff.x_b})) nphase = 2'd1;
            end else begin
               ncy = cy_ff + sy_ff;
               nerr = err_ff + (dx_ff <<< 1);
               ncx = cx_ff;
               if (nerr > dy_ff) begin ncx = cx_ff + sx_ff; nerr = nerr - (dy_ff <<< 1); end
               gx = ncx[7:0]; gy = ncy[7:0]; gvalid = 1'b1;
               if (ncy == $signed({6'b0, req_ff.y_b})) nphase = 2'd1;
            end
         end
         mpfde_pkg::CMD_CIRCLE: begin
            // cx = x, cy = y of the walk; oct selects the symmetric point
            if (cx_ff < cy_ff) begin
               gdone = 1'b1;
            end else begin
               gvalid = 1'b1;
               ox = oct_ff[2] ? cy_ff : cx_ff;
               oy = oct_ff[2] ? cx_ff : cy_ff;
               case (oct_ff[1:0])
                  2'd0: begin
                     gx = {1'b0, req_ff.x_a} + ox[7:0]; gy = {2'b0, req_ff.y_a} + oy[7:0];
                  end
                  2'd1: begin
                     gx = {1'b0, req_ff.x_a} - ox[7:0]; gy = {2'b0, req_ff.y_a} + oy[7:0];
                  end
                  2'd2: begin
                     gx = {1'b0, req_ff.x_a} - ox[7:0]; gy = {2'b0, req_ff.y_a} - oy[7:0];
                  end
                  default: begin
                     gx = {1'b0, req_ff.x_a} + ox[7:0]; gy = {2'b0, req_ff.y_a} - oy[7:0];
                  end
               endcase
               noct = oct_ff + 3'd1;
               if (oct_ff == 3'd7) begin
                  ncy = cy_ff + 12'sd1;
                  nerr = err_ff + ych_ff;
                  nych = ych_ff + 12'sd2;
                  e2 = (nerr <<< 1) + xch_ff;
                  if (e2 > 0) begin
                     ncx = cx_ff - 12'sd1; nerr = nerr + xch_ff; nxch = xch_ff + 12'sd2;
                  end
               end
            end
         end
         default: gdone = 1'b1;
      endcase
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         x_limit_ff  <= 7'd127;
         y_limit_ff  <= 6'd63;
         req_ff      <= '0;
         ret_done_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               mpfde_pkg::CSR_X_LIMIT: x_limit_ff <= csr_data;
               mpfde_pkg::CSR_Y_LIMIT: y_limit_ff <= csr_data[5:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (mpfde_pkg::AddrBits+1)'(mpfde_pkg::Depth - 1)) begin
                  state_ff <= (ret_done_ff) ? ST_DONE : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  req_ff     <= req_item;
                  rd_byte_ff <= '0;
                  first_ff   <= 1'b1;
                  phase_ff   <= '0;
                  oct_ff     <= '0;
                  j_ff       <= '0;
                  err_ff     <= '0;
                  cx_ff      <= $signed({5'b0, req_item.x_a});
                  cy_ff      <= $signed({6'b0, req_item.y_a});
                  dx_ff <= ($signed({5'b0, req_item.x_b}) >= $signed({5'b0, req_item.x_a}))
                           ? $signed({5'b0, req_item.x_b}) - $signed({5'b0, req_item.x_a})
                           : $signed({5'b0, req_item.x_a}) - $signed({5'b0, req_item.x_b});
                  dy_ff <= ($signed({6'b0, req_item.y_b}) >= $signed({6'b0, req_item.y_a}))
                           ? $signed({6'b0, req_item.y_b}) - $signed({6'b0, req_item.y_a})
                           : $signed({6'b0, req_item.y_a}) - $signed({6'b0, req_item.y_b});
                  sx_ff <= (req_item.x_b >= req_item.x_a) ? 12'sd1 : -12'sd1;
                  sy_ff <= (req_item.y_b >= req_item.y_a) ? 12'sd1 : -12'sd1;
                  xch_ff <= 12'sd1 - ($signed({5'b0, req_item.radius}) <<< 1);
                  ych_ff <= 12'sd1;
                  ret_done_ff <= (req_item.cmd == mpfde_pkg::CMD_CLEAR);
                  if (req_item.cmd == mpfde_pkg::CMD_CIRCLE) begin
                     cx_ff <= $signed({5'b0, req_item.radius});
                     cy_ff <= '0;
                  end
                  unique case (req_item.cmd)
                     mpfde_pkg::CMD_READ:  state_ff <= ST_READ1;
                     mpfde_pkg::CMD_CLEAR: begin
                        clr_ff <= '0; state_ff <= ST_CLEAR;
                     end
                     default: state_ff <= ST_GEN;
                  endcase
                  addr_ff <= mpfde_pkg::AddrBits'(req_item.x_a) * mpfde_pkg::AddrBits'(mpfde_pkg::Pages)
                             + mpfde_pkg::AddrBits'(req_item.page);
               end
            end
            ST_READ1: state_ff <= ST_READ2;
            ST_READ2: begin
               if ({1'b0, req_ff.x_a} < 8'(mpfde_pkg::Columns)
                   && {1'b0, req_ff.page} < 4'(mpfde_pkg::Pages)) begin
                  rd_byte_ff <= ram_rd;
               end
               state_ff <= ST_DONE;
            end
            ST_GEN: begin
               if (gdone && !(req_ff.cmd == mpfde_pkg::CMD_RECT && phase_ff == 2'd0)) begin
                  state_ff <= ST_DONE;
               end else begin
                  first_ff <= 1'b0;
                  cx_ff <= ncx; cy_ff <= ncy; err_ff <= nerr;
                  xch_ff <= nxch; ych_ff <= nych; j_ff <= nj;
                  phase_ff <= nphase; oct_ff <= noct;
                  if (gvalid) begin
                     px_ff  <= gx; py_ff <= gy;
                     pon_ff <= (req_ff.cmd == mpfde_pkg::CMD_PIXEL
                                || req_ff.cmd == mpfde_pkg::CMD_FILL) ? req_ff.mode : 1'b1;
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_RD: begin
               addr_ff <= mpfde_pkg::AddrBits'(px_ff[mpfde_pkg::ColBits-1:0])
                          * mpfde_pkg::AddrBits'(mpfde_pkg::Pages)
                          + mpfde_pkg::AddrBits'(px_pg);
               mask_ff  <= 8'h80 >> py_ff[2:0];
               state_ff <= px_ok ? ST_WAIT : ST_GEN;
            end
            ST_WAIT: state_ff <= ST_WR;
            ST_WR:   state_ff <= ST_GEN;
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/mpfde_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single port, one access a cycle (a write also reads the old word), registered read data.
// ----------------------------------------------------------------------------
module mpfde_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Registered read; during a write the old word is read out.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

FILE: sim/monochrome_page_framebuffer_draw_engine_tb.sv
// ----------------------------------------------------------------------------
// Draw engine testbench
// Drives pixel, fill, outline, line, circle, clear and read commands into the
// page framebuffer draw engine. A shadow framebuffer inside the bench works
// out the words the table lacks; every result word is checked field by field.
// Limit registers are changed between phases while the engine is idle.
// ----------------------------------------------------------------------------
module monochrome_page_framebuffer_draw_engine_tb;

   localparam int CycleLimit = 3000000;
   localparam int RandomPerPhase = 200;

   // One row of the directed table.
   typedef struct {
      mpfde_pkg::req_type item;
      bit                 known;
      mpfde_pkg::rsp_type answer;
   } row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   mpfde_pkg::req_type req_item;
   logic    rsp_valid;
   mpfde_pkg::rsp_type rsp_item;
   logic    csr_write;
   logic    csr_index;
   logic [6:0] csr_data;

   // Shadow copy of the store and the limit registers.
   logic [7:0] shadow_frame [mpfde_pkg::Depth];
   int         shadow_x_limit;
   int         shadow_y_limit;

   mpfde_pkg::rsp_type pending_words [$];
   row_type directed_rows [$];
   int      failures;
   int      cycle_count;

   monochrome_page_framebuffer_draw_engine uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Clock with a period of four units.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("monochrome_page_framebuffer_draw_engine test failed");
         $finish;
      end
   end

   // Result checker: every strobed word is matched with the oldest expectation.
   always @(posedge clock) begin
      mpfde_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word read_data=%h done_cmd=%0d", $time,
                     rsp_item.read_data, rsp_item.done_cmd);
            failures++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_item.read_data !== want.read_data) begin
               $display("%0t: read_data expected %h got %h", $time,
                        want.read_data, rsp_item.read_data);
               failures++;
            end
            if (rsp_item.done_cmd !== want.done_cmd) begin
               $display("%0t: done_cmd expected %0d got %0d", $time,
                        want.done_cmd, rsp_item.done_cmd);
               failures++;
            end
         end
      end
   end

   // Sets or clears one pixel, dropping it when outside the limits or store.
   function automatic void plot(int x, int y, bit on);
      int pg;
      int addr;
      x = x & 255;
      y = y & 255;
      if (x > shadow_x_limit || y > shadow_y_limit) return;
      if (y / 8 > 7) return;
      pg = 7 - y / 8;
      if (x >= mpfde_pkg::Columns || pg >= mpfde_pkg::Pages) return;
      addr = x * mpfde_pkg::Pages + pg;
      shadow_frame[addr][7 - (y % 8)] = on;
   endfunction

   // Bresenham line with the strictly-greater error threshold.
   function automatic void draw_segment(int x1, int y1, int x2, int y2);
      int dx, dy, sx, sy, cx, cy, err;
      dx = x2 - x1;
      dy = y2 - y1;
      sx = 1;
      sy = 1;
      cx = x1;
      cy = y1;
      err = 0;
      if (dx < 0) begin
         sx = -1;
         dx = -dx;
      end
      if (dy < 0) begin
         sy = -1;
         dy = -dy;
      end
      plot(x1, y1, 1'b1);
      if (dx == 0 && dy == 0) return;
      if (dy <= dx) begin
         do begin
            cx += sx;
            err += 2 * dy;
            if (err > dx) begin
               cy += sy;
               err -= 2 * dx;
            end
            plot(cx, cy, 1'b1);
         end while (cx != x2);
      end else begin
         do begin
            cy += sy;
            err += 2 * dx;
            if (err > dy) begin
               cx += sx;
               err -= 2 * dy;
            end
            plot(cx, cy, 1'b1);
         end while (cy != y2);
      end
   endfunction

   // Midpoint circle, eight octants per step.
   function automatic void draw_ring(int cx, int cy, int r);
      int x, y, xch, ych, e;
      x = r;
      y = 0;
      xch = 1 - 2 * r;
      ych = 1;
      e = 0;
      while (x >= y) begin
         plot(cx + x, cy + y, 1'b1);
         plot(cx - x, cy + y, 1'b1);
         plot(cx - x, cy - y, 1'b1);
         plot(cx + x, cy - y, 1'b1);
         plot(cx + y, cy + x, 1'b1);
         plot(cx - y, cy + x, 1'b1);
         plot(cx - y, cy - x, 1'b1);
         plot(cx + y, cy - x, 1'b1);
         y++;
         e += ych;
         ych += 2;
         if (2 * e + xch > 0) begin
            x--;
            e += xch;
            xch += 2;
         end
      end
   endfunction

   // Applies one command to the shadow store and returns its result word.
   function automatic mpfde_pkg::rsp_type draw_and_answer(mpfde_pkg::req_type it);
      mpfde_pkg::rsp_type res;
      int xa, ya, xb, yb, wid, hgt;
      xa = int'(it.x_a);
      ya = int'(it.y_a);
      xb = int'(it.x_b);
      yb = int'(it.y_b);
      wid = int'(it.width);
      hgt = int'(it.height);
      res.read_data = '0;
      res.done_cmd = it.cmd;
      case (it.cmd)
         mpfde_pkg::CMD_READ: begin
            res.read_data = shadow_frame[xa * mpfde_pkg::Pages + int'(it.page)];
         end
         mpfde_pkg::CMD_CLEAR: begin
            foreach (shadow_frame[k]) shadow_frame[k] = '0;
         end
         mpfde_pkg::CMD_PIXEL: begin
            plot(xa, ya, it.mode);
         end
         mpfde_pkg::CMD_FILL: begin
            for (int i = xa; i <= xb; i++)
               for (int j = ya; j <= yb; j++)
                  plot(i, j, it.mode);
         end
         mpfde_pkg::CMD_RECT: begin
            for (int j = 0; j < hgt; j++) begin
               plot(xa, ya + j, 1'b1);
               plot(xa + wid - 1, ya + j, 1'b1);
            end
            for (int j = 0; j < wid; j++) begin
               plot(xa + j, ya, 1'b1);
               plot(xa + j, ya + hgt - 1, 1'b1);
            end
         end
         mpfde_pkg::CMD_LINE: begin
            draw_segment(xa, ya, xb, yb);
         end
         mpfde_pkg::CMD_CIRCLE: begin
            draw_ring(xa, ya, int'(it.radius));
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Hands one command word to the engine and records what it should return.
   // The caller is at a falling edge; start is left high on return.
   task automatic issue(mpfde_pkg::req_type it, bit known, mpfde_pkg::rsp_type answer);
      mpfde_pkg::rsp_type predicted;
      start = 1'b1;
      req_item = it;
      while (busy) @(negedge clock);
      @(posedge clock);
      predicted = draw_and_answer(it);
      pending_words.push_back(known ? answer : predicted);
      @(negedge clock);
   endtask

   // Random pause on the command side; mostly short, now and then long.
   task automatic pause_sender(bit eager);
      int pick, len;
      pick = $urandom_range(0, 99);
      if (eager || pick < 55) len = 0;
      else if (pick < 92) len = $urandom_range(1, 3);
      else len = $urandom_range(5, 40);
      if (len > 0) begin
         start = 1'b0;
         repeat (len) @(negedge clock);
      end
   endtask

   // Waits until every word has come back and the engine has gone idle.
   task automatic drain;
      start = 1'b0;
      while (pending_words.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes one limit register and mirrors it in the shadow copy.
   task automatic write_limit(logic idx, int value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value[6:0];
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == mpfde_pkg::CSR_X_LIMIT) shadow_x_limit = value & 127;
      else shadow_y_limit = value & 63;
   endtask

   function automatic row_type make_row(logic [2:0] op, int xa, int ya, int xb, int yb,
                                        int rad, int wid, int hgt, bit md, int pg,
                                        bit known, int rd);
      row_type row;
      row.item.cmd = op;
      row.item.x_a = 7'(xa);
      row.item.y_a = 6'(ya);
      row.item.x_b = 7'(xb);
      row.item.y_b = 6'(yb);
      row.item.radius = 7'(rad);
      row.item.width = 8'(wid);
      row.item.height = 7'(hgt);
      row.item.mode = md;
      row.item.page = 3'(pg);
      row.known = known;
      row.answer.read_data = 8'(rd);
      row.answer.done_cmd = op;
      return row;
   endfunction

   // Random command, mostly small shapes so the run stays short.
   function automatic mpfde_pkg::req_type random_command();
      mpfde_pkg::req_type it;
      int pick;
      it = mpfde_pkg::req_type'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 25) it.cmd = mpfde_pkg::CMD_READ;
      else if (pick < 45) it.cmd = mpfde_pkg::CMD_PIXEL;
      else if (pick < 57) it.cmd = mpfde_pkg::CMD_FILL;
      else if (pick < 69) it.cmd = mpfde_pkg::CMD_RECT;
      else if (pick < 84) it.cmd = mpfde_pkg::CMD_LINE;
      else if (pick < 96) it.cmd = mpfde_pkg::CMD_CIRCLE;
      else if (pick < 98) it.cmd = mpfde_pkg::CMD_CLEAR;
      else it.cmd = 3'd7;
      case (it.cmd)
         mpfde_pkg::CMD_FILL: begin
            if ($urandom_range(0, 99) != 0) begin
               it.x_b = 7'(int'(it.x_a) + int'($urandom_range(0, 12)) - 1);
               it.y_b = 6'(int'(it.y_a) + int'($urandom_range(0, 10)) - 1);
            end
         end
         mpfde_pkg::CMD_RECT: begin
            if ($urandom_range(0, 19) != 0) begin
               it.width = 8'($urandom_range(0, 20));
               it.height = 7'($urandom_range(0, 12));
            end
         end
         mpfde_pkg::CMD_CIRCLE: begin
            if ($urandom_range(0, 19) != 0) it.radius = 7'($urandom_range(0, 20));
         end
         default: begin
         end
      endcase
      return it;
   endfunction

   // Stimulus.
   initial begin
      int limit_x [7] = '{127, 0, 127, 0, -1, -1, 127};
      int limit_y [7] = '{63, 0, 0, 63, -1, -1, 63};
      bit eager;
      failures = 0;
      cycle_count = 0;
      start = 1'b0;
      req_item = '0;
      csr_write = 1'b0;
      csr_index = mpfde_pkg::CSR_X_LIMIT;
      csr_data = '0;
      shadow_x_limit = 127;
      shadow_y_limit = 63;
      foreach (shadow_frame[k]) shadow_frame[k] = '0;
      reset = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed table: extremes, every command and the odd corners.
      directed_rows.push_back(make_row(mpfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_READ, 127, 0, 0, 0, 0, 0, 0, 0, 7, 1, 8'h00));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 7, 1, 8'h80));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_PIXEL, 127, 63, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_READ, 127, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h01));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 7, 1, 8'h00));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_FILL, 0, 0, 127, 63, 0, 0, 0, 1, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_READ, 64, 0, 0, 0, 0, 0, 0, 0, 3, 1, 8'hFF));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_FILL, 40, 30, 20, 10, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_READ, 64, 0, 0, 0, 0, 0, 0, 0, 3, 1, 8'h00));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_RECT, 120, 60, 0, 0, 0, 20, 10, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_RECT, 10, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_RECT, 3, 2, 0, 0, 0, 255, 127, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_LINE, 0, 0, 127, 63, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_LINE, 127, 0, 0, 63, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_LINE, 5, 5, 5, 5, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_LINE, 10, 0, 12, 63, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_CIRCLE, 64, 32, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_CIRCLE, 64, 32, 0, 0, 127, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_CIRCLE, 0, 0, 0, 0, 10, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(3'd7, 127, 63, 127, 63, 127, 255, 127, 1, 7, 1, 8'h00));
      directed_rows.push_back(make_row(mpfde_pkg::CMD_READ, 64, 0, 0, 0, 0, 0, 0, 0, 4, 0, 0));
      foreach (directed_rows[r]) begin
         issue(directed_rows[r].item, directed_rows[r].known, directed_rows[r].answer);
         pause_sender(1'b0);
      end

      // Random phases, each under its own limit setting.
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         write_limit(mpfde_pkg::CSR_X_LIMIT,
                     limit_x[ph] < 0 ? int'($urandom_range(0, 127)) : limit_x[ph]);
         write_limit(mpfde_pkg::CSR_Y_LIMIT,
                     limit_y[ph] < 0 ? int'($urandom_range(0, 63)) : limit_y[ph]);
         eager = (ph == 2);
         for (int n = 0; n < RandomPerPhase; n++) begin
            issue(random_command(), 1'b0, '0);
            pause_sender(eager);
         end
      end

      // Let everything come back, then settle.
      drain();
      repeat (50) @(negedge clock);
      if (failures == 0) begin
         $display("monochrome_page_framebuffer_draw_engine test passed");
      end else begin
         $display("monochrome_page_framebuffer_draw_engine test failed");
      end
      $finish;
   end

endmodule
